// ===== hdl/tcrc_pkg.sv =====
`timescale 1ns / 1ps

package tcrc_pkg;

    localparam int TIMER_COUNT = 3;
    localparam int IRQ_WIDTH   = 3;

    // Command codes
    localparam logic [2:0] CMD_READ      = 3'd0;
    localparam logic [2:0] CMD_WRITE     = 3'd1;
    localparam logic [2:0] CMD_TICK      = 3'd2;
    localparam logic [2:0] CMD_HBLANK    = 3'd3;
    localparam logic [2:0] CMD_CLEAR_IRQ = 3'd4;

    // Register select codes, offset bits 2:1
    localparam logic [1:0] REG_VALUE  = 2'd0;
    localparam logic [1:0] REG_MODE   = 2'd1;
    localparam logic [1:0] REG_TARGET = 2'd2;

    // Sync mode codes, mode bits 3:2
    localparam logic [1:0] SYNC_PRESCALE = 2'd1;
    localparam logic [1:0] SYNC_HBLANK   = 2'd2;
    localparam logic [1:0] SYNC_GATE     = 2'd3;

    // Mode bit positions
    localparam int MODE_GATE_BIT       = 0;
    localparam int MODE_TARGET_EN_BIT  = 10;
    localparam int MODE_WRAP_EN_BIT    = 11;
    localparam int MODE_TARGET_IRQ_BIT = 12;
    localparam int MODE_WRAP_IRQ_BIT   = 13;

    typedef struct packed {
        logic        tick;
        logic        clr_value;
        logic        wr_mode;
        logic        wr_target;
        logic        clr_irq;
        logic        hblank;
        logic [15:0] cycles;
        logic [15:0] data;
    } timer_ctl_t;

    typedef struct packed {
        logic [15:0] count;
        logic [15:0] mode_rd;
        logic [15:0] target;
        logic        irq_next;
    } timer_status_t;

endpackage

// ===== hdl/three_channel_root_counter_unit.sv =====
`timescale 1ns / 1ps

// Three 16-bit root counters behind a 16-bit register bus.
// Item channel (item_valid/item_ready): cmd selects a bus read, a bus write,
// a tick of tick_cycles system clocks, a new hblank level, or an irq clear
// for timer_select. offset bits 5:4 pick the timer, bits 2:1 the register
// (value, mode, target).
// Result channel (result_valid/result_ready): exactly one transfer per item,
// carrying read_data (zero unless a valid read) and irq_lines after the item.
// An accepted item lands in an input register and is processed from there;
// its result is loaded into the result register as it is processed, and a
// held result stalls processing. Throughput is one item per cycle while the
// receiver keeps result_ready high; the limit is the single combinational
// pass through the timer update logic. While result_ready is low the result
// is held, one further item may sit in the input register, and item_ready
// drops once both are occupied. Reset clears all counters, modes, targets,
// flags, the hblank level and the valid flags of both pipeline stages.
module three_channel_root_counter_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [2:0]  cmd,
    input  logic [5:0]  offset,
    input  logic [15:0] write_data,
    input  logic [15:0] tick_cycles,
    input  logic        hblank_level,
    input  logic [1:0]  timer_select,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [15:0] read_data,
    output logic [2:0]  irq_lines
);
    import tcrc_pkg::*;

    localparam logic [2:0] TIMER_LIMIT = 3'(TIMER_COUNT);

    logic        stage_valid_reg, stage_valid_next;
    logic [2:0]  cmd_reg;
    logic [5:0]  offset_reg;
    logic [15:0] data_reg;
    logic [15:0] cycles_reg;
    logic        level_reg;
    logic [1:0]  sel_reg;
    logic        hblank_reg, hblank_next;
    logic        res_valid_reg, res_valid_next;
    logic [15:0] rd_reg;
    logic [2:0]  irq_reg;

    logic          fire;
    logic          take;
    logic [1:0]    t_idx;
    logic [1:0]    r_idx;
    logic          t_ok;
    logic          sel_ok;
    logic [15:0]   rd_value;
    logic [2:0]    irq_value;
    timer_ctl_t    ctl [TIMER_COUNT];
    timer_status_t status [TIMER_COUNT];

    assign fire       = stage_valid_reg && (!res_valid_reg || result_ready);
    assign item_ready = !stage_valid_reg || fire;
    assign take       = item_valid && item_ready;

    assign t_idx  = offset_reg[5:4];
    assign r_idx  = offset_reg[2:1];
    assign t_ok   = {1'b0, t_idx} < TIMER_LIMIT;
    assign sel_ok = {1'b0, sel_reg} < TIMER_LIMIT;

    genvar g;
    generate
        for (g = 0; g < TIMER_COUNT; g++)
        begin : g_timer
            logic hit;
            logic sel_hit;
            assign hit     = fire && (t_idx == 2'(g)) && (cmd_reg == CMD_WRITE);
            assign sel_hit = fire && (sel_reg == 2'(g)) && (cmd_reg == CMD_CLEAR_IRQ);

            assign ctl[g].tick      = fire && (cmd_reg == CMD_TICK);
            assign ctl[g].clr_value = hit && (r_idx == REG_VALUE);
            assign ctl[g].wr_mode   = hit && (r_idx == REG_MODE);
            assign ctl[g].wr_target = hit && (r_idx == REG_TARGET);
            assign ctl[g].clr_irq   = sel_hit && sel_ok;
            assign ctl[g].hblank    = hblank_reg;
            assign ctl[g].cycles    = cycles_reg;
            assign ctl[g].data      = data_reg;

            tcrc_timer u_timer
            (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctl    (ctl[g]),
                .status (status[g])
            );
        end
    endgenerate

    always_comb
    begin
        rd_value = 16'd0;
        for (int i = 0; i < TIMER_COUNT; i++)
        begin
            if (t_idx == 2'(i))
            begin
                case (r_idx)
                    REG_VALUE:  rd_value = status[i].count;
                    REG_MODE:   rd_value = status[i].mode_rd;
                    REG_TARGET: rd_value = status[i].target;
                    default:    rd_value = 16'd0;
                endcase
            end
        end
        if (!t_ok || (cmd_reg != CMD_READ))
        begin
            rd_value = 16'd0;
        end
        irq_value = 3'd0;
        for (int i = 0; i < IRQ_WIDTH; i++)
        begin
            if (i < TIMER_COUNT)
            begin
                irq_value[i] = status[i].irq_next;
            end
        end
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (take)
        begin
            stage_valid_next = 1'b1;
        end
        else if (fire)
        begin
            stage_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end

        hblank_next = hblank_reg;
        if (fire && (cmd_reg == CMD_HBLANK))
        begin
            hblank_next = level_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
            hblank_reg      <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            res_valid_reg   <= res_valid_next;
            hblank_reg      <= hblank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg    <= cmd;
            offset_reg <= offset;
            data_reg   <= write_data;
            cycles_reg <= tick_cycles;
            level_reg  <= hblank_level;
            sel_reg    <= timer_select;
        end
        if (fire)
        begin
            rd_reg  <= rd_value;
            irq_reg <= irq_value;
        end
    end

    assign result_valid = res_valid_reg;
    assign read_data    = rd_reg;
    assign irq_lines    = irq_reg;

endmodule

// ===== hdl/tcrc_timer.sv =====
`timescale 1ns / 1ps

module tcrc_timer
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  tcrc_pkg::timer_ctl_t   ctl,
    output tcrc_pkg::timer_status_t status
);
    import tcrc_pkg::*;

    logic [15:0] count_reg, count_next;
    logic [15:0] mode_reg, mode_next;
    logic [15:0] target_reg, target_next;
    logic [2:0]  rest_reg, rest_next;
    logic        thit_reg, thit_next;
    logic        whit_reg, whit_next;
    logic        irq_reg, irq_next;

    logic [1:0]  sync;
    logic        running;
    logic [16:0] acc;
    logic [16:0] counts;
    logic [2:0]  rest_new;
    logic [15:0] new_count;
    logic        t_hit;
    logic        w_hit;

    always_comb
    begin
        sync    = mode_reg[3:2];
        running = !((sync == SYNC_HBLANK) && !ctl.hblank) &&
                  !((sync == SYNC_GATE) && !mode_reg[MODE_GATE_BIT]);
        acc     = {1'b0, ctl.cycles} + {14'd0, rest_reg};
        if (sync == SYNC_PRESCALE)
        begin
            counts   = {3'd0, acc[16:3]};
            rest_new = acc[2:0];
        end
        else
        begin
            counts   = acc;
            rest_new = 3'd0;
        end
        // the count wraps at 16 bits, so only the low bits of the step matter
        new_count = count_reg + counts[15:0];
        // no wrap correction on the target compare
        t_hit = mode_reg[MODE_TARGET_EN_BIT] && (count_reg < target_reg) &&
                (new_count >= target_reg);
        w_hit = mode_reg[MODE_WRAP_EN_BIT] && (new_count < count_reg);
    end

    always_comb
    begin
        count_next  = count_reg;
        mode_next   = mode_reg;
        target_next = target_reg;
        rest_next   = rest_reg;
        thit_next   = thit_reg;
        whit_next   = whit_reg;
        irq_next    = irq_reg;
        if (ctl.tick && running)
        begin
            rest_next = rest_new;
            // hold count and flags when no whole count has elapsed
            if (counts != 17'd0)
            begin
                count_next = new_count;
                thit_next  = t_hit;
                whit_next  = w_hit;
                if ((t_hit && mode_reg[MODE_TARGET_IRQ_BIT]) ||
                    (w_hit && mode_reg[MODE_WRAP_IRQ_BIT]))
                begin
                    irq_next = 1'b1;
                end
            end
        end
        if (ctl.clr_value)
        begin
            count_next = 16'd0;
        end
        if (ctl.wr_mode)
        begin
            mode_next = ctl.data;
        end
        if (ctl.wr_target)
        begin
            target_next = ctl.data;
        end
        if (ctl.clr_irq)
        begin
            irq_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            mode_reg   <= '0;
            target_reg <= '0;
            rest_reg   <= '0;
            thit_reg   <= 1'b0;
            whit_reg   <= 1'b0;
            irq_reg    <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            mode_reg   <= mode_next;
            target_reg <= target_next;
            rest_reg   <= rest_next;
            thit_reg   <= thit_next;
            whit_reg   <= whit_next;
            irq_reg    <= irq_next;
        end
    end

    assign status.count    = count_reg;
    assign status.mode_rd  = {3'd0, whit_reg, thit_reg, 1'b0, mode_reg[9:0]};
    assign status.target   = target_reg;
    assign status.irq_next = irq_next;

    a_irq_set_by_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(irq_reg) |-> $past(ctl.tick))
        else $error("irq raised without a tick");

    a_irq_clear_by_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(irq_reg) |-> $past(ctl.clr_irq))
        else $error("irq dropped without a clear");

    a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> $past(ctl.tick || ctl.clr_value))
        else $error("count changed without a tick or clear");

    a_rest_prescale: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(ctl.tick && running) && (rest_reg != 3'd0)) |->
        ($past(sync) == SYNC_PRESCALE))
        else $error("prescaler remainder left outside prescale mode");

endmodule

// ===== tb/tb_three_channel_root_counter_unit.sv =====
`timescale 1ns / 1ps

module tb_three_channel_root_counter_unit;

    import tcrc_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_ITEMS    = 1500;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 8;

    // offset bits 2:1 value with no register behind it
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [15:0]          read_data;
        logic [IRQ_WIDTH-1:0] irq_lines;
    } counter_reply_t;

    class counter_shadow;
        logic [15:0] count_q     [TIMER_COUNT];
        logic [15:0] mode_q      [TIMER_COUNT];
        logic [15:0] target_q    [TIMER_COUNT];
        logic [2:0]  rest_q      [TIMER_COUNT];
        logic        target_seen [TIMER_COUNT];
        logic        wrap_seen   [TIMER_COUNT];
        logic        irq_latched [TIMER_COUNT];
        logic        hblank_q;
        counter_reply_t awaited[$];
        int unsigned mismatches;

        function new();
            for (int k = 0; k < TIMER_COUNT; k++)
            begin
                count_q[k]     = '0;
                mode_q[k]      = '0;
                target_q[k]    = '0;
                rest_q[k]      = '0;
                target_seen[k] = 1'b0;
                wrap_seen[k]   = 1'b0;
                irq_latched[k] = 1'b0;
            end
            hblank_q   = 1'b0;
            mismatches = 0;
        endfunction

        function void note_transfer(input logic [2:0] c, input logic [5:0] off,
                                    input logic [15:0] data, input logic [15:0] cycles,
                                    input logic hb, input logic [1:0] sel);
            counter_reply_t reply;
            int unsigned    t, div, acc, steps, prior, later;
            logic [1:0]     rsel, sync;
            reply.read_data = '0;
            reply.irq_lines = '0;
            t    = 32'(off[5:4]);
            rsel = off[2:1];
            case (c)
                CMD_READ:
                    if (t < TIMER_COUNT)
                    begin
                        case (rsel)
                            REG_VALUE:  reply.read_data = count_q[t];
                            REG_MODE:   reply.read_data = {3'b000, wrap_seen[t], target_seen[t],
                                                           1'b0, mode_q[t][9:0]};
                            REG_TARGET: reply.read_data = target_q[t];
                            default: ;
                        endcase
                    end
                CMD_WRITE:
                    if (t < TIMER_COUNT)
                    begin
                        case (rsel)
                            REG_VALUE:  count_q[t]  = '0;
                            REG_MODE:   mode_q[t]   = data;
                            REG_TARGET: target_q[t] = data;
                            default: ;
                        endcase
                    end
                CMD_TICK:
                    for (int k = 0; k < TIMER_COUNT; k++)
                    begin
                        sync = mode_q[k][3:2];
                        if ((sync == SYNC_HBLANK && !hblank_q) ||
                            (sync == SYNC_GATE && !mode_q[k][MODE_GATE_BIT]))
                            continue;
                        div        = (sync == SYNC_PRESCALE) ? 8 : 1;
                        acc        = 32'(rest_q[k]) + 32'(cycles);
                        steps      = acc / div;
                        rest_q[k]  = 3'(acc % div);
                        // no whole count: flags hold their old value
                        if (steps == 0)
                            continue;
                        prior      = 32'(count_q[k]);
                        later      = (prior + steps) & 32'hFFFF;
                        count_q[k] = 16'(later);
                        target_seen[k] = mode_q[k][MODE_TARGET_EN_BIT] &&
                                         prior < 32'(target_q[k]) &&
                                         later >= 32'(target_q[k]);
                        if (target_seen[k] && mode_q[k][MODE_TARGET_IRQ_BIT])
                            irq_latched[k] = 1'b1;
                        wrap_seen[k] = mode_q[k][MODE_WRAP_EN_BIT] && later < prior;
                        if (wrap_seen[k] && mode_q[k][MODE_WRAP_IRQ_BIT])
                            irq_latched[k] = 1'b1;
                    end
                CMD_HBLANK:
                    hblank_q = hb;
                CMD_CLEAR_IRQ:
                    if (int'(sel) < TIMER_COUNT)
                        irq_latched[sel] = 1'b0;
                default: ;
            endcase
            for (int k = 0; k < TIMER_COUNT; k++)
                reply.irq_lines[k] = irq_latched[k];
            awaited.push_back(reply);
        endfunction

        function void check_result(input logic [15:0] rd, input logic [IRQ_WIDTH-1:0] lines);
            counter_reply_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: read_data %h irq_lines %b", rd, lines);
                return;
            end
            want = awaited.pop_front();
            if (rd !== want.read_data || lines !== want.irq_lines)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: read_data exp %h got %h, irq_lines exp %b got %b",
                             want.read_data, rd, want.irq_lines, lines);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    logic [2:0]  cmd;
    logic [5:0]  offset;
    logic [15:0] write_data;
    logic [15:0] tick_cycles;
    logic        hblank_level;
    logic [1:0]  timer_select;
    logic        result_valid;
    logic        result_ready;
    logic [15:0] read_data;
    logic [2:0]  irq_lines;

    counter_shadow shadow = new();

    int  burst_left;
    bit  offering;
    bit  hold_off_request;

    three_channel_root_counter_unit u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .cmd          (cmd),
        .offset       (offset),
        .write_data   (write_data),
        .tick_cycles  (tick_cycles),
        .hblank_level (hblank_level),
        .timer_select (timer_select),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .read_data    (read_data),
        .irq_lines    (irq_lines)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // note inputs before checking results so that ordering within an edge cannot matter
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                shadow.note_transfer(cmd, offset, write_data, tick_cycles,
                                     hblank_level, timer_select);
            if (result_valid && result_ready)
                shadow.check_result(read_data, irq_lines);
        end
    end

    initial
    begin
        int unsigned cycle_count;
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // receiver: phases of steady, sparse and patterned readiness, plus one long hold-off
    initial
    begin
        int  phase, span;
        bit  held;
        held = 1'b0;
        result_ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_request && !held)
            begin
                held = 1'b1;
                result_ready <= 1'b0;
                for (int n = 0; n < HOLD_OFF_CYCLES; n++)
                    @(posedge clk);
            end
            phase = $urandom_range(0, 3);
            span  = $urandom_range(8, 60);
            for (int n = 0; n < span; n++)
            begin
                case (phase)
                    0:       result_ready <= 1'b1;
                    1:       result_ready <= ($urandom_range(0, 3) != 0);
                    2:       result_ready <= (n % 3 == 0);
                    default: result_ready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    function automatic logic [5:0] reg_offset(input int timer, input logic [1:0] r);
        logic [1:0] tsel;
        logic       pad3, pad0;
        tsel = timer[1:0];
        pad3 = 1'($urandom_range(0, 1));
        pad0 = 1'($urandom_range(0, 1));
        return {tsel, pad3, r, pad0};
    endfunction

    // hold valid and payload until the transfer, then gap at the end of a burst
    task automatic offer(input logic [2:0] c, input logic [5:0] off, input logic [15:0] data,
                         input logic [15:0] cyc, input logic hb, input logic [1:0] sel);
        int gap;
        item_valid   <= 1'b1;
        cmd          <= c;
        offset       <= off;
        write_data   <= data;
        tick_cycles  <= cyc;
        hblank_level <= hb;
        timer_select <= sel;
        offering = 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                offering = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        int          pick, timer, cut;
        logic [1:0]  rsel;
        logic [15:0] data, cyc;

        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        cmd          <= CMD_READ;
        offset       <= '0;
        write_data   <= '0;
        tick_cycles  <= '0;
        hblank_level <= 1'b0;
        timer_select <= '0;
        burst_left       = 0;
        offering         = 1'b0;
        hold_off_request = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: target hit, wrap, irq clear, prescaler, hblank and gate, bad addresses
        offer(CMD_READ,  reg_offset(0, REG_MODE),   '0, '0, 1'b0, '0);
        offer(CMD_WRITE, reg_offset(0, REG_MODE),   16'h3C00, '0, 1'b0, '0);
        offer(CMD_WRITE, reg_offset(0, REG_TARGET), 16'd5, '0, 1'b0, '0);
        offer(CMD_TICK,  '0, '0, 16'd5, 1'b0, '0);
        offer(CMD_READ,  reg_offset(0, REG_MODE),   '0, '0, 1'b0, '0);
        offer(CMD_CLEAR_IRQ, '0, '0, '0, 1'b0, 2'd0);
        offer(CMD_TICK,  '0, '0, 16'hFFFF, 1'b0, '0);
        offer(CMD_CLEAR_IRQ, '0, '0, '0, 1'b0, 2'd3);
        offer(CMD_WRITE, reg_offset(0, REG_VALUE),  16'hFFFF, '0, 1'b0, '0);
        offer(CMD_READ,  reg_offset(0, REG_VALUE),  '0, '0, 1'b0, '0);
        offer(CMD_WRITE, reg_offset(1, REG_MODE),   16'h1404, '0, 1'b0, '0);
        offer(CMD_WRITE, reg_offset(1, REG_TARGET), 16'd2, '0, 1'b0, '0);
        offer(CMD_TICK,  '0, '0, 16'd7, 1'b0, '0);
        offer(CMD_TICK,  '0, '0, 16'd9, 1'b0, '0);
        offer(CMD_WRITE, reg_offset(2, REG_MODE),   16'h0008, '0, 1'b0, '0);
        offer(CMD_TICK,  '0, '0, 16'd3, 1'b0, '0);
        offer(CMD_HBLANK, '0, '0, '0, 1'b1, '0);
        offer(CMD_TICK,  '0, '0, 16'd3, 1'b0, '0);
        offer(CMD_HBLANK, '0, '0, '0, 1'b0, '0);
        offer(CMD_WRITE, reg_offset(0, REG_MODE),   16'h000C, '0, 1'b0, '0);
        offer(CMD_TICK,  '0, '0, 16'd1, 1'b0, '0);
        offer(CMD_WRITE, reg_offset(0, REG_MODE),   16'hFFFD, '0, 1'b0, '0);
        offer(CMD_TICK,  '0, '0, 16'd1, 1'b0, '0);
        offer(CMD_READ,  reg_offset(0, REG_MODE),   '0, '0, 1'b0, '0);
        offer(CMD_READ,  reg_offset(3, REG_VALUE),  '0, '0, 1'b0, '0);
        offer(CMD_WRITE, reg_offset(3, REG_MODE),   16'hFFFF, '0, 1'b0, '0);
        offer(CMD_WRITE, reg_offset(1, REG_UNUSED), 16'hFFFF, '0, 1'b0, '0);
        offer(CMD_READ,  reg_offset(1, REG_UNUSED), '0, '0, 1'b0, '0);
        for (int k = 1; k <= 3; k++)
            offer(CMD_CLEAR_IRQ + 3'(k), 6'($urandom), 16'($urandom), 16'($urandom),
                  1'($urandom), 2'($urandom));

        hold_off_request = 1'b1;

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick  = $urandom_range(0, 99);
            timer = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, TIMER_COUNT - 1);
            if (pick < 6)
                offer(3'($urandom), 6'($urandom), 16'($urandom), 16'($urandom),
                      1'($urandom), 2'($urandom));
            else if (pick < 32)
            begin
                cut = $urandom_range(0, 19);
                rsel = (cut < 3) ? REG_VALUE : (cut < 10) ? REG_MODE :
                       (cut < 18) ? REG_TARGET : REG_UNUSED;
                data = 16'($urandom);
                if (rsel == REG_MODE && $urandom_range(0, 3) != 0)
                    data[MODE_WRAP_IRQ_BIT:MODE_TARGET_EN_BIT] = '1;
                // place most targets just ahead of the counter so that hits happen
                if (rsel == REG_TARGET && timer < TIMER_COUNT && $urandom_range(0, 9) < 7)
                    data = shadow.count_q[timer] + 16'($urandom_range(1, 60));
                offer(CMD_WRITE, reg_offset(timer, rsel), data, 16'($urandom),
                      1'($urandom), 2'($urandom));
            end
            else if (pick < 60)
            begin
                cut = $urandom_range(0, 19);
                cyc = (cut < 12) ? 16'($urandom_range(0, 24)) :
                      (cut < 16) ? 16'($urandom_range(0, 700)) :
                      (cut < 18) ? 16'($urandom) : 16'hFFFF - 16'($urandom_range(0, 3));
                offer(CMD_TICK, 6'($urandom), 16'($urandom), cyc, 1'($urandom), 2'($urandom));
            end
            else if (pick < 84)
                offer(CMD_READ, reg_offset(timer, 2'($urandom)), 16'($urandom), 16'($urandom),
                      1'($urandom), 2'($urandom));
            else if (pick < 92)
                offer(CMD_HBLANK, 6'($urandom), 16'($urandom), 16'($urandom),
                      1'($urandom), 2'($urandom));
            else
                offer(CMD_CLEAR_IRQ, 6'($urandom), 16'($urandom), 16'($urandom),
                      1'($urandom), 2'($urandom));
        end

        if (offering)
        begin
            item_valid <= 1'b0;
            offering = 1'b0;
        end

        while (shadow.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (shadow.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== three_channel_root_counter_unit.f =====
hdl/tcrc_pkg.sv
hdl/tcrc_timer.sv
hdl/three_channel_root_counter_unit.sv
tb/tb_three_channel_root_counter_unit.sv
